### rtl/core/rwo_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and waveform tables for the random wavetable oscillator.
// No dependencies; used by the channel interfaces and the top level.
package rwo_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned POS_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned DAC_W       = SAMPLE_W + 1;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 1;

  localparam logic [SAMPLE_W-1:0] RAND_CAP = 8'hFB;

  localparam logic [POS_W-1:0] FULL_MASK = POS_W'(TABLE_DEPTH - 1);
  localparam logic [POS_W-1:0] HALF_MASK = POS_W'((TABLE_DEPTH >> 1) - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAW_SELECT = 1'b1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_GATE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic                double_step;
    logic                hold_table;
    logic                reset_gate;
    logic                reverse_gate;
    logic [SAMPLE_W-1:0] control_voltage;
    logic [SAMPLE_W-1:0] random_byte;
  } rwo_in_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_value;
    logic             gate_out;
  } rwo_out_t;

  localparam logic [SAMPLE_W-1:0] SINE_TAB [TABLE_DEPTH] = '{
    8'd127, 8'd103, 8'd79,  8'd56,  8'd37,  8'd21,  8'd9,   8'd2,
    8'd0,   8'd2,   8'd9,   8'd21,  8'd37,  8'd56,  8'd79,  8'd103,
    8'd127, 8'd152, 8'd176, 8'd199, 8'd218, 8'd234, 8'd246, 8'd253,
    8'd255, 8'd253, 8'd246, 8'd234, 8'd218, 8'd199, 8'd176, 8'd152
  };

  localparam logic [SAMPLE_W-1:0] SQUARE_TAB [TABLE_DEPTH] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0
  };

  localparam logic [SAMPLE_W-1:0] SAW_TAB [TABLE_DEPTH] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

endpackage

### rtl/core/rwo_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one oscillator input transaction.
// Depends on rwo_pkg for the payload type.
interface rwo_in_if
  import rwo_pkg::*;
();
  logic    valid;
  logic    ready;
  rwo_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/rwo_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one oscillator result transaction.
// Depends on rwo_pkg for the payload type.
interface rwo_out_if
  import rwo_pkg::*;
();
  logic     valid;
  logic     ready;
  rwo_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/random_wavetable_oscillator.sv
`timescale 1ns / 1ps
// Random wavetable oscillator: an accepted input transaction is staged in the input register,
// then one combinational pass writes the result register, which drives the result transaction.
// Throughput is one transaction per cycle; a tick stalls only while a result waits unread.
// Gate-event transactions update state and produce no result. Synchronous active-low reset:
// position 0, counting up, rearm set, wave store zero, config zero, pipeline empty.
module random_wavetable_oscillator
  import rwo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rwo_in_if.sink                in_stream,
  rwo_out_if.source             out_stream,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic half_mode_r;
  logic saw_sel_r;

  // Oscillator state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                rev_dir_r, rev_dir_nxt;
  logic                rearm_r, rearm_nxt;
  logic [SAMPLE_W-1:0] store_r [TABLE_DEPTH];

  // Input register stage
  logic    s1_valid_r;
  rwo_in_t s1_data_r;
  logic    s1_fire;
  logic    in_xfer;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  rwo_out_t out_data_r, out_data_nxt;

  // Combinational pass
  logic [POS_W-1:0]    step;
  logic [POS_W-1:0]    wrap_mask;
  logic [POS_W-1:0]    tick_pos;
  logic [SAMPLE_W-1:0] rnd_capped;
  logic [SAMPLE_W-1:0] new_entry;
  logic [SAMPLE_W-1:0] entry;
  logic                store_we;
  logic                is_tick;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_mode_r <= 1'b0;
      saw_sel_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_MODE:  half_mode_r <= cfg_wdata[0];
        CFG_SAW_SELECT: saw_sel_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the staged transaction moves on unless it is a tick that
  // would overwrite an unconsumed result. Gate events never wait.
  // ---------------------------------------------------------------------
  assign is_tick  = (s1_data_r.operation == OP_TICK);
  assign s1_fire  = s1_valid_r && (!is_tick || !out_valid_r || out_stream.ready);
  assign in_stream.ready = !s1_valid_r || s1_fire;
  assign in_xfer  = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid_r <= in_stream.valid;
    end
  end

  // Payload register: load on every accepted transaction, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_stream.payload;
    end
  end

  // ---------------------------------------------------------------------
  // Tick datapath: advance the phase, pick the waveform, form the result
  // ---------------------------------------------------------------------
  always_comb begin
    step       = s1_data_r.double_step ? POS_W'(2) : POS_W'(1);
    wrap_mask  = half_mode_r ? HALF_MASK : FULL_MASK;
    // Wrap in both directions by masking to the active length
    tick_pos   = (rev_dir_r ? (pos_r - step) : (pos_r + step)) & wrap_mask;
    rnd_capped = (s1_data_r.random_byte > RAND_CAP) ? RAND_CAP : s1_data_r.random_byte;
    if (rnd_capped >= s1_data_r.control_voltage) begin
      new_entry = SQUARE_TAB[tick_pos];
    end else if (saw_sel_r) begin
      new_entry = SAW_TAB[tick_pos];
    end else begin
      new_entry = SINE_TAB[tick_pos];
    end
    store_we = s1_fire && is_tick && !s1_data_r.hold_table;
    // Hold gate high: report what the store already has
    entry    = s1_data_r.hold_table ? store_r[tick_pos] : new_entry;
  end

  // ---------------------------------------------------------------------
  // State update for both transaction kinds
  // ---------------------------------------------------------------------
  always_comb begin
    pos_nxt     = pos_r;
    rev_dir_nxt = rev_dir_r;
    rearm_nxt   = rearm_r;
    if (s1_fire) begin
      if (is_tick) begin
        pos_nxt = tick_pos;
      end else if (rearm_r) begin
        // Reset gate wins over reverse; either consumes the rearm
        priority if (s1_data_r.reset_gate) begin
          pos_nxt   = '0;
          rearm_nxt = 1'b0;
        end else if (s1_data_r.reverse_gate) begin
          rev_dir_nxt = !rev_dir_r;
          rearm_nxt   = 1'b0;
        end else begin
          // Both gates low: no action on position or direction
          rearm_nxt = rearm_r;
        end
      end
      // Rearm once both gates are released, on any transaction kind
      if (!s1_data_r.reset_gate && !s1_data_r.reverse_gate) begin
        rearm_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rev_dir_r <= 1'b0;
      rearm_r   <= 1'b1;
    end else begin
      pos_r     <= pos_nxt;
      rev_dir_r <= rev_dir_nxt;
      rearm_r   <= rearm_nxt;
    end
  end

  // Wave store: cleared by reset, one entry written per tick unless the hold gate is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (store_we) begin
      store_r[tick_pos] <= new_entry;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r && !out_stream.ready;
    out_data_nxt  = out_data_r;
    if (s1_fire && is_tick) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.dac_value = half_mode_r ? {entry, 1'b0} : {1'b0, entry};
      out_data_nxt.gate_out  = ((s1_data_r.control_voltage >> 1) >= entry);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_gate_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !is_tick) |=> (out_valid_r == $past(out_valid_r && !out_stream.ready)))
    else $error("gate event produced or dropped a result");

  a_half_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_tick && half_mode_r) |=> !pos_r[POS_W-1])
    else $error("position escaped the half table");

  a_reset_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !is_tick && rearm_r && s1_data_r.reset_gate) |=> (pos_r == '0 && !rearm_r))
    else $error("armed reset gate did not zero the position");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("staged transaction lost while stalled");

endmodule
